@@ hdl/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared types, operation codes and sizing constants for the adder core.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Default capacity of each term store.
  localparam int MAX_TERMS_DEFAULT = 32;

  // Field widths of one term.
  localparam int COEF_W     = 16;
  localparam int SUM_COEF_W = 17;
  localparam int EXP_W      = 10;

  // Operation codes carried in the input transaction.
  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_START       = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [1:0]               op;
    logic signed [COEF_W-1:0] coefficient;
    logic [EXP_W-1:0]         exponent;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic signed [SUM_COEF_W-1:0] sum_coefficient;
    logic [EXP_W-1:0]             sum_exponent;
    logic                         none;
    logic                         last_term;
  } out_item_t;

  // One stored term.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         expo;
  } term_t;

  localparam int TERM_W = $bits(term_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic restart;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic last;
  } status_t;

endpackage

@@ hdl/spa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/spa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial adder controller
// Sequences loads and the merge, and holds off input while a merge runs.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        op,
  input  spa_pkg::status_t  status,
  output logic              in_stall,
  output spa_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    IDLE,
    FETCH,
    MERGE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && !in_stall;

  // Commands decoded from the current state and the accepted transaction.
  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.load_first  = accept && (op == spa_pkg::OP_LOAD_FIRST);
        cmd.load_second = accept && (op == spa_pkg::OP_LOAD_SECOND);
        cmd.restart     = accept && (op == spa_pkg::OP_START);
      end
      MERGE: begin
        cmd.emit = status.out_free;
      end
      default: begin
      end
    endcase
  end

  // State and the registered stall output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept && (op == spa_pkg::OP_START)) begin
            state    <= FETCH;
            in_stall <= 1'b1;
          end
        end
        FETCH: begin
          state <= MERGE;
        end
        MERGE: begin
          if (status.out_free && status.last) begin
            state    <= IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hdl/spa_datapath.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial adder datapath
// Term stores, fill counts, merge indices, compare and add, output register.
// ----------------------------------------------------------------------------
module spa_datapath #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  spa_pkg::in_item_t  in_data,
  input  spa_pkg::cmd_t      cmd,
  output spa_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_stall,
  output spa_pkg::out_item_t out_data
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);

  logic [CNT_W-1:0] first_count;
  logic [CNT_W-1:0] second_count;
  logic [CNT_W-1:0] i_idx;
  logic [CNT_W-1:0] j_idx;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] j_next;

  logic                     we_first;
  logic                     we_second;
  logic [CNT_W-1:0]         raddr_i;
  logic [CNT_W-1:0]         raddr_j;
  logic [spa_pkg::TERM_W-1:0] rdata_first;
  logic [spa_pkg::TERM_W-1:0] rdata_second;
  spa_pkg::term_t           load_term;
  spa_pkg::term_t           term_a;
  spa_pkg::term_t           term_b;

  logic                     a_left;
  logic                     b_left;
  logic                     take_a;
  logic                     take_b;
  logic                     take_both;
  spa_pkg::out_item_t       result;

  // Loads go to the next free entry while the store has room.
  assign we_first  = cmd.load_first  && (first_count  < FULL);
  assign we_second = cmd.load_second && (second_count < FULL);
  assign load_term = '{coef: in_data.coefficient, expo: in_data.exponent};

  // While a term is emitted the stores are read ahead at the advanced indices.
  assign raddr_i = cmd.emit ? i_next : i_idx;
  assign raddr_j = cmd.emit ? j_next : j_idx;

  spa_ram #(
    .WIDTH (spa_pkg::TERM_W),
    .DEPTH (MAX_TERMS)
  ) u_first_store (
    .clk   (clk),
    .we    (we_first),
    .waddr (first_count[IDX_W-1:0]),
    .wdata (load_term),
    .raddr (raddr_i[IDX_W-1:0]),
    .rdata (rdata_first)
  );

  spa_ram #(
    .WIDTH (spa_pkg::TERM_W),
    .DEPTH (MAX_TERMS)
  ) u_second_store (
    .clk   (clk),
    .we    (we_second),
    .waddr (second_count[IDX_W-1:0]),
    .wdata (load_term),
    .raddr (raddr_j[IDX_W-1:0]),
    .rdata (rdata_second)
  );

  assign term_a = spa_pkg::term_t'(rdata_first);
  assign term_b = spa_pkg::term_t'(rdata_second);

  // Merge step: pick the higher exponent, or add on a tie.
  always_comb begin
    a_left    = i_idx < first_count;
    b_left    = j_idx < second_count;
    take_both = 1'b0;
    take_a    = 1'b0;
    take_b    = 1'b0;
    if (a_left && b_left) begin
      take_a    = term_a.expo > term_b.expo;
      take_b    = term_a.expo < term_b.expo;
      take_both = term_a.expo == term_b.expo;
    end else if (a_left) begin
      take_a = 1'b1;
    end else if (b_left) begin
      take_b = 1'b1;
    end
    i_next = i_idx + CNT_W'(take_a || take_both);
    j_next = j_idx + CNT_W'(take_b || take_both);

    result = '0;
    if (take_both) begin
      result.sum_coefficient = {term_a.coef[spa_pkg::COEF_W-1], term_a.coef}
                             + {term_b.coef[spa_pkg::COEF_W-1], term_b.coef};
      result.sum_exponent    = term_a.expo;
    end else if (take_a) begin
      result.sum_coefficient = {term_a.coef[spa_pkg::COEF_W-1], term_a.coef};
      result.sum_exponent    = term_a.expo;
    end else if (take_b) begin
      result.sum_coefficient = {term_b.coef[spa_pkg::COEF_W-1], term_b.coef};
      result.sum_exponent    = term_b.expo;
    end
    result.none      = !a_left && !b_left;
    result.last_term = (i_next >= first_count) && (j_next >= second_count);
  end

  assign status.out_free = !out_valid || !out_stall;
  assign status.last     = result.last_term;

  // Fill counts and merge indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      i_idx        <= '0;
      j_idx        <= '0;
    end else begin
      if (we_first) begin
        first_count <= first_count + CNT_W'(1);
      end
      if (we_second) begin
        second_count <= second_count + CNT_W'(1);
      end
      if (cmd.restart) begin
        i_idx <= '0;
        j_idx <= '0;
      end else if (cmd.emit) begin
        i_idx <= i_next;
        j_idx <= j_next;
        if (result.last_term) begin
          first_count  <= '0;
          second_count <= '0;
        end
      end
    end
  end

  // Output register: filled on emit, emptied when the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= result;
    end
  end

endmodule

@@ hdl/sparse_polynomial_adder_core.sv @@
// ----------------------------------------------------------------------------
// Sparse polynomial adder core
// Loads two term lists and merges them into one sum, term by term.
// ----------------------------------------------------------------------------
// Terms are loaded one per cycle, each list in descending exponent order; a
// load into a full store is dropped. A start transaction merges the two lists:
// the input is stalled for the whole merge, the FETCH state primes the term
// store reads, and then one result leaves per cycle while the output is not
// stalled. The merge rate is set by the single read port of each term store,
// read one index ahead. The last result carries last_term; two empty lists
// give a single result with none set. Both fill counts clear when a merge
// completes. No clearing pass is needed after reset.
module sparse_polynomial_adder_core #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spa_pkg::out_item_t out_data
);

  spa_pkg::cmd_t    cmd;
  spa_pkg::status_t status;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (in_data.op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  spa_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A start transaction holds off further input from the next cycle.
  a_start_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.op == spa_pkg::OP_START)) |=> in_stall)
    else $error("input not stalled after start");

  // Input is released only together with the final result of the merge.
  a_release_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> (out_valid && out_data.last_term))
    else $error("input released without final result");

  // The empty-sum marker only appears on a final result.
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.none) |-> out_data.last_term)
    else $error("none result not marked last");

  // No result is produced outside a merge except one still waiting.
  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(in_stall))
    else $error("result produced outside a merge");

endmodule
